// File: rtl/float32_to_half_base64_encoder_assert.svh
// assertion macros shared by the checker of the single-to-half base64 encoder
// no dependencies; included by bare file name
`ifndef FLOAT32_TO_HALF_BASE64_ENCODER_ASSERT_SVH
`define FLOAT32_TO_HALF_BASE64_ENCODER_ASSERT_SVH

// same-cycle implication, ignored while reset is asserted
`define F2HB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("f2hb check failed");

// next-cycle implication, ignored while reset is asserted
`define F2HB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("f2hb check failed");

// next-cycle implication that is also checked through reset
`define F2HB_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("f2hb check failed");

`endif

// File: rtl/f2hb_pkg.sv
// shared types, constants and functions of the single-to-half base64 encoder
// no dependencies
package f2hb_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_PAD     = 8'h3D;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;

    localparam logic [15:0] HALF_INF   = 16'h7C00;
    localparam logic [15:0] HALF_QNAN  = 16'h7E00;

    // one queued piece of work: one or two base64 groups
    typedef struct packed {
        logic [23:0] grp0;       // first group, bytes msb first
        logic [23:0] grp1;       // second group, only when dual
        logic        dual;       // two groups, eight characters
        logic [1:0]  tail_len;   // valid bytes of the final group, 1 to 3
        logic        last;       // final group closes the text
    } t_grp_entry;

    // truncating single to half conversion
    function automatic logic [15:0] single_to_half(input logic [31:0] w);
        logic        sgn;
        logic [7:0]  expo;
        logic [22:0] mant;
        logic [4:0]  sh;
        logic [23:0] full_mant;
        logic [23:0] shifted;
        logic [15:0] res;
        sgn       = w[31];
        expo      = w[30:23];
        mant      = w[22:0];
        sh        = 5'(8'd126 - expo);
        full_mant = {1'b1, mant};
        shifted   = full_mant >> sh;
        if (expo == 8'hFF) begin
            if (mant == 23'd0) begin
                res = HALF_INF;
            end else begin
                res = HALF_QNAN | {6'd0, mant[22:13]};
            end
        end else if (expo == 8'd0) begin
            res = 16'd0;
        end else if (expo >= 8'd143) begin
            res = HALF_INF;
        end else if (expo <= 8'd112) begin
            if (expo < 8'd102) begin
                res = 16'd0;
            end else begin
                res = {6'd0, shifted[9:0]};
            end
        end else begin
            res = {1'b0, 5'(expo - 8'd112), mant[22:13]};
        end
        res[15] = sgn;
        return res;
    endfunction

    // standard base64 alphabet
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = CHAR_UPPER_A + {2'd0, v};
        end else if (v < 6'd52) begin
            c = CHAR_LOWER_A + {2'd0, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = CHAR_DIGIT_0 + {2'd0, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = CHAR_PLUS;
        end else begin
            c = CHAR_SLASH;
        end
        return c;
    endfunction

endpackage

// File: rtl/f2hb_front.sv
// front part: converts each single word to half, merges it with pending bytes
// and builds base64 group entries; depends on f2hb_pkg
module f2hb_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [31:0]          i_float_bits,
    input  logic                 i_last_value,
    input  logic                 i_q_full,
    output logic                 o_push,
    output f2hb_pkg::t_grp_entry o_entry
);
    import f2hb_pkg::*;

    logic [15:0] r_bytes, n_bytes;
    logic [1:0]  r_cnt, n_cnt;
    logic [15:0] half;
    logic        accept;
    logic        push_need;
    logic [7:0]  p0, p1, hlo, hhi;

    assign half    = single_to_half(i_float_bits);
    assign hlo     = half[7:0];
    assign hhi     = half[15:8];
    assign p0      = r_bytes[7:0];
    assign p1      = r_bytes[15:8];
    assign accept  = i_valid && !i_q_full;
    assign o_stall = i_q_full;
    assign o_push  = accept && push_need;

    always_comb begin
        o_entry   = '0;
        push_need = 1'b1;
        n_bytes   = 16'd0;
        n_cnt     = 2'd0;
        if (r_cnt[1]) begin
            // two waiting bytes: one full group; the byte left over waits, or on the last value ends a second group
            o_entry.grp0 = {p0, p1, hlo};
            if (i_last_value) begin
                o_entry.dual     = 1'b1;
                o_entry.grp1     = {hhi, 16'd0};
                o_entry.tail_len = 2'd1;
                o_entry.last     = 1'b1;
            end else begin
                o_entry.tail_len = 2'd3;
                n_bytes          = {8'd0, hhi};
                n_cnt            = 2'd1;
            end
        end else if (r_cnt[0]) begin
            o_entry.grp0     = {p0, hlo, hhi};
            o_entry.tail_len = 2'd3;
            o_entry.last     = i_last_value;
        end else begin
            o_entry.grp0     = {hlo, hhi, 8'd0};
            o_entry.tail_len = 2'd2;
            o_entry.last     = i_last_value;
            push_need        = i_last_value;
            if (!i_last_value) begin
                n_bytes = half;
                n_cnt   = 2'd2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= 2'd0;
            r_bytes <= 16'd0;
        end else if (accept) begin
            r_cnt   <= n_cnt;
            r_bytes <= n_bytes;
        end
    end

endmodule

// File: rtl/f2hb_queue.sv
// short queue of group entries between front and back parts
// depends on f2hb_pkg
module f2hb_queue #(
    parameter int DEPTH = f2hb_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  f2hb_pkg::t_grp_entry i_entry,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output f2hb_pkg::t_grp_entry o_head
);
    import f2hb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_grp_entry    r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/f2hb_back.sv
// back part: walks the queued groups and sends one base64 character a cycle while the receiver does not stall
// depends on f2hb_pkg
module f2hb_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  f2hb_pkg::t_grp_entry i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_text_char,
    output logic                 o_end_of_text
);
    import f2hb_pkg::*;

    logic [2:0]  r_idx, n_idx;
    logic        r_valid;
    logic [7:0]  r_char, n_char;
    logic        r_end, n_end;
    logic        load, fire, final_char, final_grp, pad;
    logic [23:0] grp;
    logic [5:0]  sextet;

    assign load       = !r_valid || !i_stall;
    assign fire       = load && !i_q_empty;
    assign final_char = i_head.dual ? (r_idx == 3'd7) : (r_idx == 3'd3);
    assign final_grp  = !i_head.dual || r_idx[2];
    assign grp        = r_idx[2] ? i_head.grp1 : i_head.grp0;
    assign o_pop      = fire && final_char;

    always_comb begin
        case (r_idx[1:0])
            2'd0:    sextet = grp[23:18];
            2'd1:    sextet = grp[17:12];
            2'd2:    sextet = grp[11:6];
            default: sextet = grp[5:0];
        endcase
        pad = final_grp && (((r_idx[1:0] == 2'd2) && (i_head.tail_len < 2'd2)) ||
                            ((r_idx[1:0] == 2'd3) && (i_head.tail_len < 2'd3)));
        n_char = pad ? CHAR_PAD : b64_char(sextet);
        n_end  = final_char && i_head.last;
        n_idx  = final_char ? 3'd0 : r_idx + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (fire) begin
            r_valid <= 1'b1;
            r_idx   <= n_idx;
        end else if (load) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_char <= n_char;
            r_end  <= n_end;
        end
    end

    assign o_valid       = r_valid;
    assign o_text_char   = r_char;
    assign o_end_of_text = r_end;

endmodule

// File: rtl/float32_to_half_base64_encoder.sv
// top level of the single-to-half base64 encoder
// instantiates f2hb_front, f2hb_queue and f2hb_back; depends on f2hb_pkg
//
// Each request on the input carries one IEEE single-precision bit pattern. It
// is cut down to half precision (mantissa truncated, infinity kept, NaN kept
// as a quiet NaN with its top ten payload bits, single subnormals to signed
// zero, overflow to infinity, tiny values to half subnormals or zero), its two
// bytes go low byte first into a byte stream, and the stream leaves as base64
// text, one character per output request. A request with last_value set
// closes the text: waiting bytes are flushed with '=' padding and
// end_of_text marks the final character. A request yields 0, 4 or 8
// characters, 8/3 on average. The front part takes one request per cycle as
// long as the group queue (QUEUE_DEPTH entries) has room; the back part sends
// one character per cycle while the receiver does not stall, so the
// sustained rate is set by that single character lane. A character
// passes through the group queue and the output register of the back
// part on its way out. No clearing pass after reset.
module float32_to_half_base64_encoder #(
    parameter int QUEUE_DEPTH = f2hb_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_float_bits,
    input  logic        i_last_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_text_char,
    output logic        o_end_of_text
);
    import f2hb_pkg::*;

    // front to queue
    logic       q_push;
    t_grp_entry q_in;
    logic       q_full;
    // queue to back
    logic       q_pop;
    logic       q_empty;
    t_grp_entry q_head;

    // conversion, pending bytes and group building
    f2hb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_float_bits (i_float_bits),
        .i_last_value (i_last_value),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_entry      (q_in)
    );

    // decouples request intake from character output
    f2hb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // character lane with registered output
    f2hb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_head        (q_head),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_text_char   (o_text_char),
        .o_end_of_text (o_end_of_text)
    );

endmodule

// File: rtl/f2hb_checker.sv
// port-level checks of the single-to-half base64 encoder, bound to the top
// depends on f2hb_pkg and float32_to_half_base64_encoder_assert.svh
`include "float32_to_half_base64_encoder_assert.svh"

module f2hb_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_text_char,
    input logic        o_end_of_text
);
    import f2hb_pkg::*;

    logic char_ok;
    logic in_seen;
    logic out_held;
    logic out_pad;
    logic mid_pad;

    assign in_seen  = i_valid && !o_stall;
    assign out_held = o_valid && i_stall;
    assign out_pad  = o_valid && (o_text_char == CHAR_PAD);
    assign mid_pad  = out_pad && !i_stall && !o_end_of_text;
    assign char_ok = ((o_text_char >= CHAR_UPPER_A) && (o_text_char <= CHAR_UPPER_Z)) ||
                     ((o_text_char >= CHAR_LOWER_A) && (o_text_char <= CHAR_LOWER_Z)) ||
                     ((o_text_char >= CHAR_DIGIT_0) && (o_text_char <= CHAR_DIGIT_9)) ||
                     (o_text_char == CHAR_PLUS) || (o_text_char == CHAR_SLASH) ||
                     (o_text_char == CHAR_PAD);

    // a held character stays put
    `F2HB_ASSERT_NEXT(a_hold, out_held, o_valid && $stable(o_text_char) && $stable(o_end_of_text))
    // only alphabet characters or padding
    `F2HB_ASSERT_NOW(a_alphabet, o_valid, char_ok)
    // padding in the middle of the text is followed at once by more padding
    `F2HB_ASSERT_NEXT(a_pad_run, mid_pad, out_pad)
    // no character right after reset
    `F2HB_ASSERT_RST(a_reset, !i_rst_n, !o_valid)
    // an idle output stays idle unless a request was taken just before
    `F2HB_ASSERT_NEXT(a_idle_holds, !o_valid && !$past(in_seen), !o_valid)

endmodule

bind float32_to_half_base64_encoder f2hb_port_checker u_f2hb_checker (.*);

// File: sim/f2hb_checker.sv
// checker of the single-to-half base64 encoder: predicts the text for each request
// and compares every character leaving the block; no package needed
module f2hb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_float_bits,
    input  logic        i_last_value,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_text_char,
    input  logic        i_end_of_text,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam logic [7:0] PAD_CHAR = "=";

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } text_exp_t;

    text_exp_t   text_q[$];
    logic [15:0] held_bytes = '0;
    logic [1:0]  held_count = '0;
    int          fails      = 0;
    int          checked    = 0;

    // truncating single to half
    function automatic logic [15:0] to_half(input logic [31:0] w);
        logic        sgn;
        logic [7:0]  ex;
        logic [22:0] frac;
        logic [23:0] full;
        int          he;
        logic [15:0] h;
        sgn  = w[31];
        ex   = w[30:23];
        frac = w[22:0];
        full = {1'b1, frac};
        he   = int'(ex) - 112;
        if (ex == 8'hFF) begin
            h = (frac == '0) ? {sgn, 5'h1F, 10'd0} : {sgn, 5'h1F, 1'b1, frac[21:13]};
        end else if (ex == 8'd0) begin
            h = {sgn, 15'd0};
        end else if (he >= 31) begin
            h = {sgn, 5'h1F, 10'd0};
        end else if (he <= 0) begin
            if (he < -10) begin
                h = {sgn, 15'd0};
            end else begin
                h = {sgn, 5'd0, 10'(full >> (14 - he))};
            end
        end else begin
            h = {sgn, 5'(he), frac[22:13]};
        end
        return h;
    endfunction

    function automatic logic [7:0] b64_of(input logic [5:0] v);
        return ALPHABET[8*(63-int'(v)) +: 8];
    endfunction

    // one group of four characters from nb valid bytes
    task automatic push_group(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input int nb);
        logic [23:0] t;
        t = {b0, (nb > 1) ? b1 : 8'h00, (nb > 2) ? b2 : 8'h00};
        text_q.insert(text_q.size(), text_exp_t'{b64_of(t[23:18]), 1'b0});
        text_q.insert(text_q.size(), text_exp_t'{b64_of(t[17:12]), 1'b0});
        text_q.insert(text_q.size(),
                      text_exp_t'{(nb > 1) ? b64_of(t[11:6]) : PAD_CHAR, 1'b0});
        text_q.insert(text_q.size(),
                      text_exp_t'{(nb > 2) ? b64_of(t[5:0]) : PAD_CHAR, 1'b0});
    endtask

    task automatic predict_value(input logic [31:0] w, input logic lst);
        logic [7:0]  bytes_b [4];
        logic [15:0] h;
        int          n;
        int          pos;
        int          start;
        h          = to_half(w);
        start      = text_q.size();
        n          = (held_count > 2'd2) ? 2 : int'(held_count);
        pos        = 0;
        bytes_b[0] = held_bytes[7:0];
        bytes_b[1] = held_bytes[15:8];
        bytes_b[2] = 8'h00;
        bytes_b[3] = 8'h00;
        bytes_b[n]     = h[7:0];
        bytes_b[n + 1] = h[15:8];
        n += 2;
        if (n >= 3) begin
            push_group(bytes_b[0], bytes_b[1], bytes_b[2], 3);
            pos = 3;
        end
        n -= pos;
        if (lst) begin
            if (n > 0) begin
                push_group(bytes_b[pos], bytes_b[pos + 1], 8'h00, n);
            end
            if (text_q.size() > start) begin
                text_q[text_q.size() - 1].eot = 1'b1;
            end
            held_bytes = '0;
            held_count = '0;
        end else begin
            held_bytes = '0;
            if (n > 0) held_bytes[7:0] = bytes_b[pos];
            if (n > 1) held_bytes[15:8] = bytes_b[pos + 1];
            held_count = 2'(n);
        end
    endtask

    always @(posedge i_clk) begin
        text_exp_t exp_c;
        if (!i_rst_n) begin
            text_q.delete();
            held_bytes = '0;
            held_count = '0;
        end else begin
            // characters first: none can come from a request taken at this edge
            if (i_out_valid && !i_out_stall) begin
                checked++;
                if (text_q.size() == 0) begin
                    $error("text_char %h end_of_text %b arrived with nothing expected",
                           i_text_char, i_end_of_text);
                    fails++;
                end else begin
                    exp_c = text_q.pop_front();
                    if (i_text_char !== exp_c.ch) begin
                        $error("text_char mismatch: expected %h, got %h",
                               exp_c.ch, i_text_char);
                        fails++;
                    end
                    if (i_end_of_text !== exp_c.eot) begin
                        $error("end_of_text mismatch: expected %b, got %b",
                               exp_c.eot, i_end_of_text);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_value(i_float_bits, i_last_value);
            end
        end
        o_pending    <= text_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// File: sim/tb.sv
// top of the testbench for the single-to-half base64 encoder: clock, reset,
// stimulus and verdict; depends on float32_to_half_base64_encoder and f2hb_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_VALUES = 88;   // random values per idle/stall mix
    localparam int HOLD_CYCLES  = 200;  // long receiver hold-off
    localparam int DRAIN_CYCLES = 16;   // quiet cycles after the last character
    localparam int EDGE_COUNT   = 20;

    // directed values: zeros, infinities, nans, single subnormals, overflow,
    // the edges of the half normal and subnormal ranges, plain numbers
    localparam logic [31:0] EDGE_VALUES [0:EDGE_COUNT-1] = '{
        32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
        32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h0000_0001,
        32'h807F_FFFF, 32'h7F7F_FFFF, 32'h477F_E000, 32'h4780_0000,
        32'h3880_0000, 32'h387F_FFFF, 32'h3300_0000, 32'h3380_0000,
        32'h32FF_FFFF, 32'h3F80_0000, 32'hC020_0000, 32'h5555_AAAA
    };
    // texts of 1, 2, 3, 4, 5 and 5 values: every padding case at the end
    localparam logic [EDGE_COUNT-1:0] EDGE_LAST = 20'b1000_0100_0010_0010_0101;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [31:0] i_float_bits = '0;
    logic        i_last_value = 1'b0;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_text_char;
    logic        o_end_of_text;

    int fail_count;
    int chars_waiting;
    int chars_checked;
    int send_idle  = 0;   // percent of cycles the sender stays idle
    int stall_pct  = 0;   // percent of cycles the receiver stalls
    int hold_left  = 0;   // cycles of forced receiver stall still to go
    int values_sent = 0;
    int texts_sent  = 0;

    always #1 i_clk = ~i_clk;

    float32_to_half_base64_encoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_float_bits  (i_float_bits),
        .i_last_value  (i_last_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_text_char   (o_text_char),
        .o_end_of_text (o_end_of_text)
    );

    f2hb_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_float_bits  (i_float_bits),
        .i_last_value  (i_last_value),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_text_char   (o_text_char),
        .i_end_of_text (o_end_of_text),
        .o_fail_count  (fail_count),
        .o_pending     (chars_waiting),
        .o_checked     (chars_checked)
    );

    // receiver: random stall, or a forced hold-off counted down here
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // hard stop if the block hangs
    initial begin
        #1ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // random single pattern, weighted toward every conversion case
    function automatic logic [31:0] rand_float();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(9))
            0: w[30:23] = 8'hFF;                                // nan
            1: begin                                            // infinity
                w[30:23] = 8'hFF;
                w[22:0]  = '0;
            end
            2: w[30:23] = 8'h00;                                // single subnormal, zero
            3: w[30:23] = 8'($urandom_range(143, 254));         // overflow
            4: w[30:23] = 8'($urandom_range(102, 112));         // half subnormal, zero at the low end
            5: w[30:23] = 8'($urandom_range(1, 101));           // underflow to zero
            6, 7: w[30:23] = 8'($urandom_range(113, 142));      // half normal
            default: ;                                          // raw bits
        endcase
        return w;
    endfunction

    // offer one request after a random idle stretch, hold it until taken
    task automatic send_value(input logic [31:0] w, input logic lst);
        while ($urandom_range(99) < send_idle) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_float_bits <= w;
        i_last_value <= lst;
        do @(posedge i_clk); while (o_stall);
        values_sent++;
        if (lst) texts_sent++;
    endtask

    // stop offering until every predicted character has come out
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end while (chars_waiting != 0);
    endtask

    initial begin
        int          phase;
        int          k;
        logic        lst;
        logic [31:0] w;

        // synchronous reset held low from the start, released at a falling edge
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, no idling
        for (k = 0; k < EDGE_COUNT; k++) begin
            send_value(EDGE_VALUES[k], EDGE_LAST[k]);
        end
        wait_drained();

        // random part: four mixes of sender idling and receiver stalling
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle = 0;  stall_pct = 0;  end
                1: begin send_idle = 79; stall_pct = 0;  end
                2: begin send_idle = 0;  stall_pct = 79; end
                default: begin send_idle = 33; stall_pct = 33; end
            endcase
            for (k = 0; k < PHASE_VALUES; k++) begin
                // long hold-off while requests keep coming: queue fills, input stalls
                if (phase == 0 && k == 30) hold_left = HOLD_CYCLES;
                // sender pause until the text so far has fully left
                if (phase == 1 && k == 40) wait_drained();
                w   = rand_float();
                lst = (k == PHASE_VALUES - 1) || ($urandom_range(5) == 0);
                send_value(w, lst);
            end
            wait_drained();
        end

        // quiet spell of DRAIN_CYCLES to catch any stray character
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d values in %0d texts, %0d characters checked,",
                 values_sent, texts_sent, chars_checked);
        $display("under free flow, sender idling, receiver stalling and both mixed");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
